### rtl/bcs_pkg.sv
// Package: constants, types and state codes shared by the charge supervisor
`default_nettype none
package bcs_pkg;
    localparam int AVERAGE_SLOTS_DEF     = 8;
    localparam int OVER_CHARGE_LIMIT_DEF = 8;
    localparam int DIV_BITS              = 32;

    localparam logic [3:0] REG_LOW_LEVEL  = 4'd0;
    localparam logic [3:0] REG_FULL_LEVEL = 4'd1;
    localparam logic [3:0] REG_MARGIN     = 4'd2;
    localparam logic [3:0] REG_NEAR_LEVEL = 4'd3;
    localparam logic [3:0] REG_CHG_LEVEL  = 4'd4;
    localparam logic [3:0] REG_PERIOD     = 4'd5;

    localparam int REQ_FULL   = 0;
    localparam int REQ_NEAR   = 1;
    localparam int REQ_UNPLUG = 2;
    localparam int REQ_PLUG   = 3;
    localparam int REQ_LOW    = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCALE,
        ST_DIVIDE,
        ST_AVERAGE,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic start;
        logic prep;
        logic scale;
        logic div_step;
        logic avg_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic regulate;
        logic div_last;
        logic avg_last;
    } stat_t;

    typedef struct packed {
        logic [11:0] low_level;
        logic [11:0] full_level;
        logic [11:0] margin;
        logic [11:0] near_level;
        logic [11:0] chg_level;
        logic [7:0]  period;
    } cfg_t;
endpackage
`default_nettype wire

### rtl/bcs_ctrl.sv
// Controller: sequences decision, scaling, serial divide and averaging
`default_nettype none
module bcs_ctrl
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_fire,
    input  wire              out_fire,
    input  bcs_pkg::stat_t   stat,
    output bcs_pkg::cmd_t    cmd,
    output logic             in_ready,
    output logic             out_valid
);
    bcs_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bcs_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_fire)
            out_valid_next = 1'b0;
        case (state_reg)
            bcs_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.start  = 1'b1;
                    state_next = bcs_pkg::ST_PREP;
                end
            end
            bcs_pkg::ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = stat.regulate ? bcs_pkg::ST_SCALE : bcs_pkg::ST_OUTPUT;
            end
            bcs_pkg::ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = bcs_pkg::ST_DIVIDE;
            end
            bcs_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = bcs_pkg::ST_AVERAGE;
            end
            bcs_pkg::ST_AVERAGE:
            begin
                cmd.avg_step = 1'b1;
                if (stat.avg_last)
                    state_next = bcs_pkg::ST_OUTPUT;
            end
            bcs_pkg::ST_OUTPUT:
            begin
                if (!out_valid_reg || out_fire)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = bcs_pkg::ST_IDLE;
                end
            end
            default: state_next = bcs_pkg::ST_IDLE;
        endcase
    end

    assign in_ready  = (state_reg == bcs_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
endmodule
`default_nettype wire

### rtl/bcs_datapath.sv
// Datapath: supervisor state, target duty divide, slot averaging, result word
`default_nettype none
module bcs_datapath #(
    parameter int AVERAGE_SLOTS     = bcs_pkg::AVERAGE_SLOTS_DEF,
    parameter int OVER_CHARGE_LIMIT = bcs_pkg::OVER_CHARGE_LIMIT_DEF
)
(
    input  wire             clk,
    input  wire             rst_n,
    input  bcs_pkg::cfg_t   cfg,
    input  wire  [31:0]     in_word,
    input  bcs_pkg::cmd_t   cmd,
    output bcs_pkg::stat_t  stat,
    output logic [23:0]     out_word
);
    localparam int SW = $clog2(AVERAGE_SLOTS);
    localparam int SUMW = 8 + SW + 1;
    localparam int DW = bcs_pkg::DIV_BITS;
    localparam int CW = $clog2(DW);

    logic [11:0] bat_reg, chg_reg;
    logic [6:0]  flags_reg;
    logic        charging_reg, full_reg, near_reg, alarm_reg, lowp_reg, pwm_reg;
    logic [3:0]  occ_reg;
    logic [4:0]  req_reg;
    logic [7:0]  duty_reg;
    logic [SW-1:0] idx_reg;
    logic [7:0]  slots_reg [AVERAGE_SLOTS];
    logic        inhibit_reg, shut_reg;
    logic [23:0] out_reg;
    logic [12:0] eff_reg;
    logic [19:0] prod_reg;
    logic [DW-1:0] num_reg, quo_reg;
    logic [20:0] rem_reg;
    logic [20:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic [SW-1:0] avg_idx_reg;
    logic [SUMW-1:0] sum_reg;

    // decision logic
    logic tick, plug, fullc, nearc, lowc, active, stalled;
    logic c_chg, c_full, c_near, c_alarm, c_lowp, c_pwm, c_inh, c_shut;
    logic [3:0] c_occ;
    logic [4:0] c_req;
    logic [7:0] c_duty;
    logic [12:0] full_sum;

    assign {stalled, active, lowc, nearc, fullc, plug, tick} = flags_reg;
    assign full_sum = {1'b0, cfg.full_level} + {1'b0, cfg.margin};

    always_comb
    begin
        c_chg = charging_reg; c_full = full_reg; c_near = near_reg;
        c_alarm = alarm_reg; c_lowp = lowp_reg; c_pwm = pwm_reg;
        c_occ = occ_reg; c_req = req_reg; c_duty = duty_reg; c_shut = 1'b0;
        c_inh = (bat_reg < cfg.low_level);
        if (!c_inh)
            c_req[bcs_pkg::REQ_LOW] = 1'b0;
        if (charging_reg)
        begin
            if (!full_reg)
            begin
                if ({1'b0, bat_reg} >= full_sum)
                begin
                    c_duty = '0;
                    if (c_occ != 4'd15)
                        c_occ = c_occ + 4'd1;
                end
                else if (bat_reg >= cfg.full_level)
                    c_req[bcs_pkg::REQ_FULL] = 1'b1;
                else if (bat_reg >= cfg.near_level)
                    c_req[bcs_pkg::REQ_NEAR] = 1'b1;
                else
                begin
                    c_req[bcs_pkg::REQ_FULL] = 1'b0;
                    c_req[bcs_pkg::REQ_NEAR] = 1'b0;
                end
                if (nearc)
                    c_near = 1'b1;
                if (fullc || c_occ >= 4'(OVER_CHARGE_LIMIT))
                begin
                    c_occ = '0; c_full = 1'b1; c_pwm = 1'b0; c_duty = '0;
                end
            end
            c_req[bcs_pkg::REQ_UNPLUG] = (chg_reg < cfg.chg_level);
            if (!plug)
            begin
                c_chg = 1'b0;
                c_req[bcs_pkg::REQ_FULL] = 1'b0;
                c_req[bcs_pkg::REQ_NEAR] = 1'b0;
                c_near = 1'b0; c_full = 1'b0; c_occ = '0; c_lowp = 1'b1;
            end
        end
        else
        begin
            if (active)
            begin
                c_req[bcs_pkg::REQ_LOW] = (bat_reg <= cfg.low_level);
                if (lowc && !lowp_reg && !stalled)
                    c_alarm = 1'b1;
            end
            c_req[bcs_pkg::REQ_PLUG] = (chg_reg >= cfg.chg_level);
            if (plug)
            begin
                c_chg = 1'b1; c_req[bcs_pkg::REQ_LOW] = 1'b0; c_alarm = 1'b0;
                c_pwm = 1'b1; c_shut = 1'b1; c_lowp = 1'b0;
            end
        end
    end

    // banded offset of battery value; bat*157/1000 by reciprocal multiply
    logic [12:0] eff_c;
    logic [39:0] b157;
    logic [11:0] b157k;
    always_comb
    begin
        b157  = 40'(bat_reg) * 40'd168577494;
        b157k = 12'(b157 >> 30);
        eff_c = {1'b0, bat_reg};
        if (bat_reg <= 12'd2752)      eff_c = eff_c + 13'd37;
        else if (bat_reg <= 12'd2964) eff_c = eff_c + 13'd27;
        else if (bat_reg <= 12'd3091) eff_c = eff_c + 13'd16;
        else if (bat_reg > 12'd3227)  eff_c = eff_c - 13'(b157k) + 13'd506;
        eff_c = eff_c + 13'd900;
        if (bat_reg >= 12'd3515)      eff_c = eff_c - 13'd600;
    end

    logic [21:0] trial;
    assign trial = {rem_reg, num_reg[DW-1]} - {1'b0, dvs_reg};

    // payload, divider and averaging registers
    logic [DW-1:0] quo_n;
    logic [20:0]   rem_n;
    always_comb
    begin
        quo_n = {quo_reg[DW-2:0], ~trial[21]};
        rem_n = trial[21] ? {rem_reg[19:0], num_reg[DW-1]} : trial[20:0];
    end

    logic [7:0] target_c;
    always_comb
    begin
        if (eff_reg == '0 || quo_n == '0 || quo_n >= DW'(cfg.period))
            target_c = '0;
        else
            target_c = cfg.period - quo_n[7:0];
    end

    logic [7:0] slot_new;
    logic [8:0] slot_sum;
    assign slot_sum = 9'(slots_reg[idx_reg]) + 9'(target_c);
    assign slot_new = slot_sum[8:1];

    logic [15:0] sum_all, up_bound, dn_bound;
    assign sum_all  = 16'(sum_reg) + 16'(slots_reg[avg_idx_reg]);
    assign up_bound = 16'(AVERAGE_SLOTS) * (16'(duty_reg) + 16'd1);
    assign dn_bound = 16'(AVERAGE_SLOTS) * 16'(duty_reg);

    logic [SW-1:0] idx_inc;
    assign idx_inc = (32'(idx_reg) + 1 >= AVERAGE_SLOTS) ? '0 : idx_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            charging_reg <= 1'b0; full_reg <= 1'b0; near_reg <= 1'b0;
            alarm_reg <= 1'b0; lowp_reg <= 1'b0; pwm_reg <= 1'b0;
            occ_reg <= '0; req_reg <= '0; duty_reg <= '0; idx_reg <= '0;
            for (int i = 0; i < AVERAGE_SLOTS; i++)
                slots_reg[i] <= '0;
        end
        else
        begin
            if (cmd.prep)
            begin
                charging_reg <= c_chg; full_reg <= c_full; near_reg <= c_near;
                alarm_reg <= c_alarm; lowp_reg <= c_lowp; pwm_reg <= c_pwm;
                occ_reg <= c_occ; req_reg <= c_req; duty_reg <= c_duty;
                if (c_chg)
                    idx_reg <= idx_inc;
            end
            if (cmd.div_step && stat.div_last)
                slots_reg[idx_reg] <= slot_new;
            if (cmd.avg_step && stat.avg_last && tick)
            begin
                if (sum_all >= up_bound)     duty_reg <= duty_reg + 8'd1;
                else if (sum_all < dn_bound) duty_reg <= duty_reg - 8'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            bat_reg   <= in_word[11:0];
            chg_reg   <= in_word[23:12];
            flags_reg <= in_word[30:24];
        end
        if (cmd.prep)
        begin
            inhibit_reg <= c_inh;
            shut_reg    <= c_shut;
            eff_reg     <= eff_c;
            prod_reg    <= 20'(chg_reg) * 20'(cfg.period);
        end
        if (cmd.scale)
        begin
            num_reg <= DW'(27'(prod_reg) * 27'd94);
            dvs_reg <= 21'(eff_reg) * 21'd147;
            rem_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            num_reg <= {num_reg[DW-2:0], 1'b0};
            quo_reg <= quo_n;
            rem_reg <= rem_n;
            cnt_reg <= cnt_reg + 1'b1;
            if (stat.div_last)
            begin
                avg_idx_reg <= '0;
                sum_reg     <= '0;
            end
        end
        if (cmd.avg_step)
        begin
            sum_reg     <= sum_reg + SUMW'(slots_reg[avg_idx_reg]);
            avg_idx_reg <= avg_idx_reg + 1'b1;
        end
        if (cmd.finish)
            out_reg <= {3'b0, req_reg, shut_reg, lowp_reg, alarm_reg, inhibit_reg,
                        near_reg, full_reg, charging_reg, pwm_reg, duty_reg};
    end

    assign stat.regulate = c_chg;
    assign stat.div_last = (cnt_reg == CW'(DW - 1));
    assign stat.avg_last = (32'(avg_idx_reg) == AVERAGE_SLOTS - 1);
    assign out_word = out_reg;
endmodule
`default_nettype wire

### rtl/battery_charge_supervisor_unit.sv
// Top level: battery charge supervisor with stream ports and APB registers
//  channel | dir | handshake         | payload
//  s_axis  | in  | tvalid/tready     | tdata 32b
//  m_axis  | out | tvalid/tready     | tdata 24b
//  apb     | in  | psel/penable      | 32b
// A charging word runs accept, decide, scale, 32 divider steps, one step per averaging
// slot and output; any other word runs accept, decide and output.
// Reset clears all supervisor state and the averaging slots at once.
// One word at a time; a waiting result holds in the output register and stalls
// the next word at its output step.
`default_nettype none
module battery_charge_supervisor_unit #(
    parameter int AVERAGE_SLOTS     = bcs_pkg::AVERAGE_SLOTS_DEF,
    parameter int OVER_CHARGE_LIMIT = bcs_pkg::OVER_CHARGE_LIMIT_DEF
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // battery_sample, charger_sample, adjust_tick, plug_confirmed, full_confirmed,
    // near_full_confirmed, low_confirmed, device_active, motor_stalled, pad
    input  wire  [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // duty_count, pwm_on, is_charging, is_full, is_near_full, power_on_inhibit,
    // low_alarm_on, low_power_allowed, shutdown_request, qualify_requests, pad
    output logic [23:0] m_axis_tdata,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    bcs_pkg::cfg_t  cfg_reg;
    bcs_pkg::cmd_t  cmd;
    bcs_pkg::stat_t stat;
    logic in_fire, out_fire, wr;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign pready   = 1'b1;
    assign wr       = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_level  <= 12'd2600;
            cfg_reg.full_level <= 12'd3500;
            cfg_reg.margin     <= 12'd40;
            cfg_reg.near_level <= 12'd3400;
            cfg_reg.chg_level  <= 12'd1000;
            cfg_reg.period     <= 8'd255;
        end
        else if (wr)
        begin
            case ({1'b0, paddr[4:2]})
                bcs_pkg::REG_LOW_LEVEL:  cfg_reg.low_level  <= pwdata[11:0];
                bcs_pkg::REG_FULL_LEVEL: cfg_reg.full_level <= pwdata[11:0];
                bcs_pkg::REG_MARGIN:     cfg_reg.margin     <= pwdata[11:0];
                bcs_pkg::REG_NEAR_LEVEL: cfg_reg.near_level <= pwdata[11:0];
                bcs_pkg::REG_CHG_LEVEL:  cfg_reg.chg_level  <= pwdata[11:0];
                bcs_pkg::REG_PERIOD:     cfg_reg.period     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case ({1'b0, paddr[4:2]})
            bcs_pkg::REG_LOW_LEVEL:  prdata = {20'd0, cfg_reg.low_level};
            bcs_pkg::REG_FULL_LEVEL: prdata = {20'd0, cfg_reg.full_level};
            bcs_pkg::REG_MARGIN:     prdata = {20'd0, cfg_reg.margin};
            bcs_pkg::REG_NEAR_LEVEL: prdata = {20'd0, cfg_reg.near_level};
            bcs_pkg::REG_CHG_LEVEL:  prdata = {20'd0, cfg_reg.chg_level};
            bcs_pkg::REG_PERIOD:     prdata = {24'd0, cfg_reg.period};
            default:                 prdata = '0;
        endcase
    end

    bcs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
        .stat(stat), .cmd(cmd), .in_ready(s_axis_tready), .out_valid(m_axis_tvalid)
    );

    bcs_datapath #(
        .AVERAGE_SLOTS(AVERAGE_SLOTS), .OVER_CHARGE_LIMIT(OVER_CHARGE_LIMIT)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg), .in_word(s_axis_tdata),
        .cmd(cmd), .stat(stat), .out_word(m_axis_tdata)
    );

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd)) else $error("several commands at once");
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> m_axis_tvalid) else $error("result lost");
    a_start_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> !s_axis_tready) else $error("accepted while busy");
endmodule
`default_nettype wire

### verif/battery_charge_supervisor_unit_tb.sv
// Testbench for the battery charge supervisor: predicts each result word and checks it
`default_nettype none
module battery_charge_supervisor_unit_tb;

    typedef struct packed {
        logic        stalled;
        logic        active;
        logic        lowc;
        logic        nearc;
        logic        fullc;
        logic        plug;
        logic        tick;
        logic [11:0] chg;
        logic [11:0] bat;
    } sample_t;

    typedef struct packed {
        logic [4:0] req;
        logic       shutdown;
        logic       lowpwr;
        logic       alarm;
        logic       inhibit;
        logic       near;
        logic       full;
        logic       charging;
        logic       pwm;
        logic [7:0] duty;
    } status_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    wire         s_axis_tready;
    logic [31:0] s_axis_tdata;   // bat[11:0], chg[23:12], tick, plug, full, near, low, active, stall
    wire         m_axis_tvalid;
    logic        m_axis_tready;
    wire  [23:0] m_axis_tdata;   // duty[7:0], pwm, chg, full, near, inhibit, alarm, lowpwr, shdn, req[4:0]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    wire  [31:0] prdata;
    wire         pready;

    battery_charge_supervisor_unit uut (.*);

    // predictor state
    int unsigned lvl_low, lvl_full, lvl_margin, lvl_near, lvl_chg, period;
    bit          charging, full_f, near_f, alarm_f, lowpwr_f, pwm_f;
    int unsigned over_cnt;
    bit [4:0]    req_bits;
    bit [7:0]    duty;
    bit [7:0]    slots [8];
    int unsigned slot_pos;

    status_t     expected_status [$];
    int          mismatches;
    bit          stall_rx;
    bit          busy_mode;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int unsigned duty_target(int unsigned bat, int unsigned chg);
        int unsigned eff;
        int unsigned q;
        eff = bat;
        if (bat <= 2752) eff += 37;
        else if (bat <= 2964) eff += 27;
        else if (bat <= 3091) eff += 16;
        else if (bat > 3227) eff -= (bat * 157 / 1000) - 506;
        eff += 900;
        if (bat >= 3515) eff -= 600;
        if (eff == 0) return 0;
        q = (chg * period * 94 / 147) / eff;
        if (q == 0 || q >= period) return 0;
        return period - q;
    endfunction

    function automatic status_t supervise(sample_t s);
        status_t     r;
        bit          inh;
        bit          shd;
        int unsigned t;
        int unsigned sum;
        shd = 1'b0;
        inh = s.bat < lvl_low;
        if (!inh) req_bits[bcs_pkg::REQ_LOW] = 1'b0;
        if (charging)
        begin
            if (!full_f)
            begin
                if (s.bat >= lvl_full + lvl_margin)
                begin
                    duty = '0;
                    if (over_cnt < 15) over_cnt++;
                end
                else if (s.bat >= lvl_full) req_bits[bcs_pkg::REQ_FULL] = 1'b1;
                else if (s.bat >= lvl_near) req_bits[bcs_pkg::REQ_NEAR] = 1'b1;
                else
                begin
                    req_bits[bcs_pkg::REQ_FULL] = 1'b0;
                    req_bits[bcs_pkg::REQ_NEAR] = 1'b0;
                end
                if (s.nearc) near_f = 1'b1;
                if (s.fullc || over_cnt >= 8)
                begin
                    over_cnt = 0;
                    full_f = 1'b1;
                    pwm_f = 1'b0;
                    duty = '0;
                end
            end
            req_bits[bcs_pkg::REQ_UNPLUG] = s.chg < lvl_chg;
            if (!s.plug)
            begin
                charging = 1'b0;
                req_bits[bcs_pkg::REQ_FULL] = 1'b0;
                req_bits[bcs_pkg::REQ_NEAR] = 1'b0;
                near_f = 1'b0;
                full_f = 1'b0;
                over_cnt = 0;
                lowpwr_f = 1'b1;
            end
        end
        else
        begin
            if (s.active)
            begin
                req_bits[bcs_pkg::REQ_LOW] = s.bat <= lvl_low;
                if (s.lowc && !lowpwr_f && !s.stalled) alarm_f = 1'b1;
            end
            req_bits[bcs_pkg::REQ_PLUG] = s.chg >= lvl_chg;
            if (s.plug)
            begin
                charging = 1'b1;
                req_bits[bcs_pkg::REQ_LOW] = 1'b0;
                alarm_f = 1'b0;
                pwm_f = 1'b1;
                shd = 1'b1;
                lowpwr_f = 1'b0;
            end
        end
        if (charging)
        begin
            t = duty_target(s.bat, s.chg);
            slot_pos = (slot_pos + 1) % 8;
            slots[slot_pos] = 8'((slots[slot_pos] + t) >> 1);
            sum = 0;
            for (int k = 0; k < 8; k++) sum += slots[k];
            sum = sum / 8;
            if (s.tick)
            begin
                if (sum > duty) duty++;
                else if (sum < duty) duty--;
            end
        end
        r.duty = duty;
        r.pwm = pwm_f;
        r.charging = charging;
        r.full = full_f;
        r.near = near_f;
        r.inhibit = inh;
        r.alarm = alarm_f;
        r.lowpwr = lowpwr_f;
        r.shutdown = shd;
        r.req = req_bits;
        return r;
    endfunction

    task automatic idle_gap();
        int n;
        if (busy_mode) return;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        repeat (n) @(posedge clk);
    endtask

    task automatic send_sample(sample_t s);
        idle_gap();
        s_axis_tdata <= {1'b0, s};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        expected_status.push_back(supervise(s));
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_reg(logic [3:0] idx, int unsigned val);
        while (expected_status.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx[2:0], 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            bcs_pkg::REG_LOW_LEVEL:  lvl_low = val & 12'hFFF;
            bcs_pkg::REG_FULL_LEVEL: lvl_full = val & 12'hFFF;
            bcs_pkg::REG_MARGIN:     lvl_margin = val & 12'hFFF;
            bcs_pkg::REG_NEAR_LEVEL: lvl_near = val & 12'hFFF;
            bcs_pkg::REG_CHG_LEVEL:  lvl_chg = val & 12'hFFF;
            bcs_pkg::REG_PERIOD:     period = val & 8'hFF;
            default: ;
        endcase
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            m_axis_tready <= stall_rx ? ($urandom_range(0, 3) == 0) : 1'b1;
    end

    always @(posedge clk)
    begin
        status_t got;
        status_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[20:0];
            if (expected_status.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", got);
            end
            else
            begin
                want = expected_status.pop_front();
                if (got !== want || m_axis_tdata[23:21] !== 3'd0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    function automatic sample_t random_sample(int plug_bias);
        sample_t s;
        s = 31'($urandom);
        case ($urandom_range(0, 3))
            0: s.bat = 12'($urandom_range(3300, 3700));
            1: s.bat = 12'($urandom_range(2500, 3300));
            default: ;
        endcase
        if ($urandom_range(0, 1)) s.chg = 12'($urandom_range(800, 3000));
        s.plug = $urandom_range(0, 99) < plug_bias;
        s.fullc = $urandom_range(0, 19) == 0;
        return s;
    endfunction

    task automatic test_field_extremes();
        sample_t s;
        s = '0;
        send_sample(s);
        s = '1;
        send_sample(s);
        for (int b = 0; b < 4096; b += 300)
        begin
            s = '0;
            s.bat = 12'(b);
            s.chg = 12'(4095 - b);
            s.plug = 1'b1;
            s.tick = 1'b1;
            send_sample(s);
        end
        s = '0;
        s.active = 1'b1;
        s.lowc = 1'b1;
        s.bat = 12'd100;
        send_sample(s);
        s.stalled = 1'b1;
        send_sample(s);
    endtask

    task automatic test_over_charge();
        sample_t s;
        s = '0;
        s.plug = 1'b1;
        s.tick = 1'b1;
        s.chg = 12'd2000;
        s.bat = 12'd3000;
        repeat (10) send_sample(s);
        s.bat = 12'd4000;
        s.nearc = 1'b1;
        repeat (10) send_sample(s);
        s.plug = 1'b0;
        send_sample(s);
    endtask

    task automatic test_random(int n, int plug_bias);
        repeat (n) send_sample(random_sample(plug_bias));
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b1;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        stall_rx = 1'b0;
        busy_mode = 1'b0;
        lvl_low = 2600; lvl_full = 3500; lvl_margin = 40;
        lvl_near = 3400; lvl_chg = 1000; period = 255;
        charging = 0; full_f = 0; near_f = 0; alarm_f = 0; lowpwr_f = 0; pwm_f = 0;
        over_cnt = 0; req_bits = 0; duty = 0; slot_pos = 0;
        foreach (slots[k]) slots[k] = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_over_charge();
        stall_rx = 1'b1;
        test_random(500, 85);
        write_reg(bcs_pkg::REG_PERIOD, 1);
        write_reg(bcs_pkg::REG_MARGIN, 0);
        write_reg(bcs_pkg::REG_CHG_LEVEL, 0);
        busy_mode = 1'b1;
        stall_rx = 1'b0;
        test_random(300, 85);
        busy_mode = 1'b0;
        write_reg(bcs_pkg::REG_PERIOD, 0);
        write_reg(bcs_pkg::REG_LOW_LEVEL, 4095);
        write_reg(bcs_pkg::REG_FULL_LEVEL, 4095);
        write_reg(bcs_pkg::REG_NEAR_LEVEL, 0);
        write_reg(bcs_pkg::REG_MARGIN, 4095);
        write_reg(bcs_pkg::REG_CHG_LEVEL, 4095);
        stall_rx = 1'b1;
        test_random(300, 50);
        write_reg(bcs_pkg::REG_PERIOD, 128);
        write_reg(bcs_pkg::REG_LOW_LEVEL, 0);
        write_reg(bcs_pkg::REG_FULL_LEVEL, 3450);
        write_reg(bcs_pkg::REG_NEAR_LEVEL, 3350);
        write_reg(bcs_pkg::REG_MARGIN, 60);
        write_reg(bcs_pkg::REG_CHG_LEVEL, 1200);
        test_random(700, 90);

        while (expected_status.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire

### filelist.f
rtl/bcs_pkg.sv
rtl/bcs_ctrl.sv
rtl/bcs_datapath.sv
rtl/battery_charge_supervisor_unit.sv
verif/battery_charge_supervisor_unit_tb.sv
